[hdl/sbb_pkg.sv]
// shared types and constants of the separable box blur unit
// no dependencies
`default_nettype none

package sbb_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_RADIUS_DEF = 15;

    localparam int PIX_W      = 8;
    localparam int SUM_W      = 18;
    localparam int DIV_W      = 14;
    localparam int HEIGHT_W   = 16;
    localparam int RADIUS_W   = 4;
    localparam int FWIDTH_W   = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS = 2'd2;

    localparam logic [FWIDTH_W-1:0] RST_FRAME_WIDTH   = 12'd640;
    localparam logic [HEIGHT_W-1:0] RST_FRAME_HEIGHT  = 16'd480;
    localparam logic [RADIUS_W-1:0] RST_WINDOW_RADIUS = 4'd1;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic             pixel_valid;
    } pixel_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] blurred_value;
        logic             last_of_frame;
    } pixel_out_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

[hdl/separable_box_blur_unit.sv]
// Edge-normalized box blur over a raster stream of 8-bit pixels.
// Input channel s_*: one pixel_in_t per item; pixel_valid 0 marks a drain item
// that stores nothing but may release a pending result. Result channel m_*:
// blurred_value and last_of_frame. Config port cfg_*: write frame_width,
// frame_height or window_radius; a write restarts the frame.
// Pixels live in a ring of 2*MAX_RADIUS+2 rows in one ram. An item is taken
// only while the control is idle, one at a time. An item that releases no
// result only passes the check state; one that does then reads its clipped
// window one pixel per cycle through the single ram read port, and the sum
// goes through the serial divider, is rounded and clamped, and waits for
// the output slot. Results trail input by R rows plus R pixels.
// Reset (aresetn low, synchronous) clears positions and loads the default
// registers 640x480, radius 1; ram contents are left as they are.
// A result waits in the output register while m_ready is low; the next item
// is still taken meanwhile, and the following result waits for the slot.
`default_nettype none

module separable_box_blur_unit #(
    parameter int MAX_WIDTH  = sbb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = sbb_pkg::MAX_RADIUS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output      logic                             s_ready,
    input  wire sbb_pkg::pixel_in_t               s_data,
    output      logic                             m_valid,
    input  wire logic                             m_ready,
    output      sbb_pkg::pixel_out_t              m_data,
    input  wire logic                             cfg_we,
    input  wire logic [sbb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [sbb_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = sbb_pkg::HEIGHT_W;
    localparam int RING  = 2 * MAX_RADIUS + 2;
    localparam int RW    = $clog2(RING);
    localparam int DEPTH = RING * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int KW    = $clog2(2 * MAX_RADIUS + 2);
    localparam int RADW  = sbb_pkg::RADIUS_W;

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_SUM, S_FLUSH, S_DSTART, S_DWAIT, S_OUT
    } state_t;

    state_t state_reg;

    logic [sbb_pkg::FWIDTH_W-1:0] fw_reg;
    logic [HW-1:0]                fh_reg;
    logic [RADW-1:0]              fr_reg;

    logic [WW-1:0]   eff_w;
    logic [CW-1:0]   wm1;
    logic [HW-1:0]   eff_h;
    logic [HW-1:0]   hm1;
    logic [RADW-1:0] eff_r;

    // input side position
    logic [HW-1:0] in_row_reg;
    logic [CW-1:0] in_col_reg;
    logic [RW-1:0] in_ring_reg;
    // output side position
    logic [HW-1:0] oy_reg;
    logic [CW-1:0] ox_reg;
    logic [RW-1:0] o_ring_reg;

    // window walk
    logic [HW-1:0] y1_reg, ry_reg;
    logic [CW-1:0] x0_reg, x1_reg, rx_reg;
    logic [RW-1:0] rr_reg;
    logic [KW-1:0] hc_reg, wc_reg;
    logic [sbb_pkg::DIV_W-1:0] d_reg;
    logic [sbb_pkg::SUM_W-1:0] sum_reg;
    logic                      rd_vld_reg;
    logic [sbb_pkg::PIX_W-1:0] q_reg;

    logic                 m_valid_reg;
    sbb_pkg::pixel_out_t  m_data_reg;

    logic accept;
    logic wr_en;
    logic [AW-1:0] waddr, raddr;
    logic [sbb_pkg::PIX_W-1:0] rdata;
    logic rd_en;

    logic [HW:0]   oy_pr;
    logic [HW-1:0] y1_c, y0_c;
    logic [CW:0]   ox_pr;
    logic [CW-1:0] x1_c, x0_c;
    logic [RADW-1:0] dy_c;
    logic [RW:0]   ring_y0_c;
    logic          emit_c;
    logic          last_c;

    sbb_pkg::div_req_t div_req;
    sbb_pkg::div_rsp_t div_rsp;

    logic [sbb_pkg::DIV_W:0]   two_rem;
    logic                      round_up;
    logic [sbb_pkg::SUM_W:0]   q_round;

    // effective register values
    always_comb begin
        if (fw_reg == '0) begin
            eff_w = WW'(1);
        end else if (32'(fw_reg) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(fw_reg);
        end
        wm1   = CW'(eff_w - WW'(1));
        eff_h = (fh_reg == '0) ? HW'(1) : fh_reg;
        hm1   = eff_h - HW'(1);
        eff_r = (32'(fr_reg) > MAX_RADIUS) ? RADW'(MAX_RADIUS) : fr_reg;
    end

    // clipped window of the next output
    always_comb begin
        oy_pr = {1'b0, oy_reg} + (HW+1)'(eff_r);
        y1_c  = (oy_pr > {1'b0, hm1}) ? hm1 : oy_pr[HW-1:0];
        y0_c  = (oy_reg > HW'(eff_r)) ? oy_reg - HW'(eff_r) : '0;
        dy_c  = (oy_reg > HW'(eff_r)) ? eff_r : RADW'(oy_reg);
        ox_pr = {1'b0, ox_reg} + (CW+1)'(eff_r);
        x1_c  = (ox_pr > {1'b0, wm1}) ? wm1 : ox_pr[CW-1:0];
        x0_c  = ({1'b0, ox_reg} > (CW+1)'(eff_r)) ? ox_reg - CW'(eff_r) : '0;
        if ((RW+1)'(o_ring_reg) >= (RW+1)'(dy_c)) begin
            ring_y0_c = (RW+1)'(o_ring_reg) - (RW+1)'(dy_c);
        end else begin
            ring_y0_c = (RW+1)'(o_ring_reg) + (RW+1)'(RING) - (RW+1)'(dy_c);
        end
        emit_c = (in_row_reg > y1_c) || (in_row_reg == y1_c && in_col_reg > x1_c);
        last_c = (ox_reg == wm1) && (oy_reg == hm1);
    end

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign wr_en   = accept && s_data.pixel_valid && (in_row_reg < eff_h);
    assign waddr   = AW'(in_ring_reg) * AW'(MAX_WIDTH) + AW'(in_col_reg);
    assign rd_en   = (state_reg == S_SUM);
    assign raddr   = AW'(rr_reg) * AW'(MAX_WIDTH) + AW'(rx_reg);

    sbb_ram #(
        .WIDTH (sbb_pkg::PIX_W),
        .DEPTH (DEPTH)
    ) u_row_store (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (waddr),
        .wdata (s_data.pixel_value),
        .re    (rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign div_req.start    = (state_reg == S_DSTART);
    assign div_req.dividend = sum_reg;
    assign div_req.divisor  = d_reg;

    sbb_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // round to nearest, ties to even, then clamp
    always_comb begin
        two_rem  = {div_rsp.remainder, 1'b0};
        round_up = (two_rem > {1'b0, d_reg}) ||
                   (two_rem == {1'b0, d_reg} && div_rsp.quotient[0]);
        q_round  = {1'b0, div_rsp.quotient} + (sbb_pkg::SUM_W+1)'(round_up);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fw_reg      <= sbb_pkg::RST_FRAME_WIDTH;
            fh_reg      <= sbb_pkg::RST_FRAME_HEIGHT;
            fr_reg      <= sbb_pkg::RST_WINDOW_RADIUS;
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            in_ring_reg <= '0;
            oy_reg      <= '0;
            ox_reg      <= '0;
            o_ring_reg  <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            rd_vld_reg <= rd_en;
            if (rd_vld_reg) begin
                sum_reg <= sum_reg + sbb_pkg::SUM_W'(rdata);
            end
            // the output state refills the slot itself
            if (m_valid_reg && m_ready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_we && (cfg_index == sbb_pkg::REG_FRAME_WIDTH ||
                           cfg_index == sbb_pkg::REG_FRAME_HEIGHT ||
                           cfg_index == sbb_pkg::REG_WINDOW_RADIUS)) begin
                if (cfg_index == sbb_pkg::REG_FRAME_WIDTH) begin
                    fw_reg <= cfg_wdata[sbb_pkg::FWIDTH_W-1:0];
                end
                if (cfg_index == sbb_pkg::REG_FRAME_HEIGHT) begin
                    fh_reg <= cfg_wdata[HW-1:0];
                end
                if (cfg_index == sbb_pkg::REG_WINDOW_RADIUS) begin
                    fr_reg <= cfg_wdata[RADW-1:0];
                end
                in_row_reg  <= '0;
                in_col_reg  <= '0;
                in_ring_reg <= '0;
                oy_reg      <= '0;
                ox_reg      <= '0;
                o_ring_reg  <= '0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        if (wr_en) begin
                            if (in_col_reg == wm1) begin
                                in_col_reg <= '0;
                                in_row_reg <= in_row_reg + 1'b1;
                                in_ring_reg <= (in_ring_reg == RW'(RING - 1)) ?
                                               '0 : in_ring_reg + 1'b1;
                            end else begin
                                in_col_reg <= in_col_reg + 1'b1;
                            end
                        end
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (emit_c) begin
                        y1_reg  <= y1_c;
                        ry_reg  <= y0_c;
                        x0_reg  <= x0_c;
                        x1_reg  <= x1_c;
                        rx_reg  <= x0_c;
                        rr_reg  <= (ring_y0_c >= (RW+1)'(RING)) ?
                                   RW'(ring_y0_c - (RW+1)'(RING)) : RW'(ring_y0_c);
                        hc_reg  <= KW'(y1_c - y0_c) + KW'(1);
                        wc_reg  <= KW'(x1_c - x0_c) + KW'(1);
                        sum_reg <= '0;
                        state_reg <= S_SUM;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_SUM: begin
                    if (rx_reg == x1_reg) begin
                        rx_reg <= x0_reg;
                        if (ry_reg == y1_reg) begin
                            state_reg <= S_FLUSH;
                        end else begin
                            ry_reg <= ry_reg + 1'b1;
                            rr_reg <= (rr_reg == RW'(RING - 1)) ? '0 : rr_reg + 1'b1;
                        end
                    end else begin
                        rx_reg <= rx_reg + 1'b1;
                    end
                end
                S_FLUSH: begin
                    // last read data lands in the sum at this edge
                    d_reg     <= sbb_pkg::DIV_W'(hc_reg) * sbb_pkg::DIV_W'(wc_reg);
                    state_reg <= S_DSTART;
                end
                S_DSTART: begin
                    state_reg <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (div_rsp.done) begin
                        q_reg <= (q_round > (sbb_pkg::SUM_W+1)'(255)) ?
                                 8'hff : q_round[sbb_pkg::PIX_W-1:0];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg                <= 1'b1;
                        m_data_reg.blurred_value   <= q_reg;
                        m_data_reg.last_of_frame   <= last_c;
                        if (last_c) begin
                            in_row_reg  <= '0;
                            in_col_reg  <= '0;
                            in_ring_reg <= '0;
                            oy_reg      <= '0;
                            ox_reg      <= '0;
                            o_ring_reg  <= '0;
                        end else if (ox_reg == wm1) begin
                            ox_reg     <= '0;
                            oy_reg     <= oy_reg + 1'b1;
                            o_ring_reg <= (o_ring_reg == RW'(RING - 1)) ?
                                          '0 : o_ring_reg + 1'b1;
                        end else begin
                            ox_reg <= ox_reg + 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

[hdl/sbb_ram.sv]
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module sbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[hdl/sbb_div.sv]
// restoring divider, one quotient bit per cycle
// depends on sbb_pkg
`default_nettype none

module sbb_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire sbb_pkg::div_req_t req,
    output      sbb_pkg::div_rsp_t rsp
);

    localparam int CNT_W = $clog2(sbb_pkg::SUM_W + 1);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [sbb_pkg::SUM_W-1:0]   quo_reg;
    logic [sbb_pkg::DIV_W-1:0]   rem_reg;
    logic [sbb_pkg::DIV_W-1:0]   dvs_reg;
    logic [sbb_pkg::DIV_W:0]     rem_sh;
    logic                        fits;

    assign rem_sh = {rem_reg, quo_reg[sbb_pkg::SUM_W-1]};
    assign fits   = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(sbb_pkg::SUM_W);
                quo_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                if (fits) begin
                    rem_reg <= sbb_pkg::DIV_W'(rem_sh - {1'b0, dvs_reg});
                end else begin
                    rem_reg <= rem_sh[sbb_pkg::DIV_W-1:0];
                end
                quo_reg <= {quo_reg[sbb_pkg::SUM_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

[hdl/sbb_checker.sv]
// port level checks of the box blur unit, bound to the top level
// depends on sbb_pkg and separable_box_blur_unit
`default_nettype none

module sbb_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire sbb_pkg::pixel_out_t m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while busy");

    // reset empties the result slot
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // an item taken while the slot is empty does not show its result at once
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result appeared with no work done");

endmodule

bind separable_box_blur_unit sbb_checker u_sbb_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

[tb/sv/testbench.sv]
// self-checking testbench of the separable box blur unit
// depends on sbb_pkg and separable_box_blur_unit; runs directed rows, then random frames
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRED_MAX_W  = sbb_pkg::MAX_WIDTH_DEF;
    localparam int PRED_MAX_R  = sbb_pkg::MAX_RADIUS_DEF;
    localparam int RING_ROWS   = 2 * PRED_MAX_R + 2;
    localparam int IDLE_LIMIT  = 20000;
    localparam int SETTLE      = 80;
    localparam int HOLD_CYCLES = 2500;
    localparam int RAND_ITEMS  = 1300;

    typedef enum {ROW_CFG, ROW_PIX} row_kind_t;
    typedef struct {
        row_kind_t                      kind;
        logic [sbb_pkg::CFG_IDX_W-1:0]  idx;
        logic [sbb_pkg::CFG_DATA_W-1:0] data;
        sbb_pkg::pixel_in_t             px;
        bit                             typed;
        sbb_pkg::pixel_out_t            want;
    } stim_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    sbb_pkg::pixel_in_t  s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    sbb_pkg::pixel_out_t m_data;
    logic                           cfg_we = 1'b0;
    logic [sbb_pkg::CFG_IDX_W-1:0]  cfg_index = sbb_pkg::REG_FRAME_WIDTH;
    logic [sbb_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    separable_box_blur_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // blur predictor state
    logic [sbb_pkg::PIX_W-1:0]    pix_ring [RING_ROWS*PRED_MAX_W];
    int unsigned                  px_in_pos = 0;
    int unsigned                  px_out_pos = 0;
    logic [sbb_pkg::FWIDTH_W-1:0] reg_width = sbb_pkg::RST_FRAME_WIDTH;
    logic [sbb_pkg::HEIGHT_W-1:0] reg_height = sbb_pkg::RST_FRAME_HEIGHT;
    logic [sbb_pkg::RADIUS_W-1:0] reg_radius = sbb_pkg::RST_WINDOW_RADIUS;

    sbb_pkg::pixel_out_t blur_expected [$];
    int  errors = 0;
    int  results_checked = 0;
    int  items_sent = 0;
    bit  frame_done = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_req = 0;
    int  hold_cnt = 0;
    int  quiet_cycles = 0;

    function automatic int unsigned eff_w();
        if (reg_width == 0) return 1;
        if (reg_width > PRED_MAX_W) return PRED_MAX_W;
        return reg_width;
    endfunction

    function automatic int unsigned eff_total();
        return eff_w() * ((reg_height == 0) ? 1 : reg_height);
    endfunction

    function automatic void blur_step(input sbb_pkg::pixel_in_t it, output bit emit,
                                      output sbb_pkg::pixel_out_t res);
        int unsigned w, h, r, total, oy, ox, y0, y1, x0, x1, need, d, q, rem, acc;
        w = eff_w();
        h = (reg_height == 0) ? 1 : reg_height;
        r = (reg_radius > PRED_MAX_R) ? PRED_MAX_R : reg_radius;
        total = w * h;
        emit = 0;
        res = '0;
        if (it.pixel_valid && px_in_pos < total) begin
            pix_ring[((px_in_pos / w) % RING_ROWS) * PRED_MAX_W + px_in_pos % w] = it.pixel_value;
            px_in_pos++;
        end
        if (px_out_pos >= total) begin
            px_in_pos = 0;
            px_out_pos = 0;
            return;
        end
        oy = px_out_pos / w;
        ox = px_out_pos % w;
        y1 = (oy + r < h - 1) ? oy + r : h - 1;
        x1 = (ox + r < w - 1) ? ox + r : w - 1;
        need = y1 * w + x1;
        if (px_in_pos <= need) return;
        y0 = (oy > r) ? oy - r : 0;
        x0 = (ox > r) ? ox - r : 0;
        acc = 0;
        for (int unsigned y = y0; y <= y1; y++)
            for (int unsigned x = x0; x <= x1; x++)
                acc += pix_ring[(y % RING_ROWS) * PRED_MAX_W + x];
        acc &= 32'h3FFFF;
        d = (y1 - y0 + 1) * (x1 - x0 + 1);
        q = acc / d;
        rem = acc % d;
        // round to nearest, ties to even
        if (2 * rem > d || (2 * rem == d && q[0])) q++;
        if (q > 255) q = 255;
        px_out_pos++;
        emit = 1;
        res.blurred_value = q[sbb_pkg::PIX_W-1:0];
        res.last_of_frame = (px_out_pos == total);
        if (px_out_pos == total) begin
            px_in_pos = 0;
            px_out_pos = 0;
        end
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    task automatic send_item(input sbb_pkg::pixel_in_t it, input bit typed,
                             input sbb_pkg::pixel_out_t want);
        bit emit;
        sbb_pkg::pixel_out_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        blur_step(it, emit, res);
        if (typed) blur_expected.push_back(want);
        else if (emit) blur_expected.push_back(res);
        if (emit && res.last_of_frame) frame_done = 1;
    endtask

    task automatic write_reg(input logic [sbb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sbb_pkg::CFG_DATA_W-1:0] val);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (blur_expected.size() != 0) @(posedge aclk);
        // items that release no result may still be in flight
        repeat (SETTLE) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            sbb_pkg::REG_FRAME_WIDTH:   reg_width = val[sbb_pkg::FWIDTH_W-1:0];
            sbb_pkg::REG_FRAME_HEIGHT:  reg_height = val[sbb_pkg::HEIGHT_W-1:0];
            sbb_pkg::REG_WINDOW_RADIUS: reg_radius = val[sbb_pkg::RADIUS_W-1:0];
            default: ;
        endcase
        px_in_pos = 0;
        px_out_pos = 0;
    endtask

    function automatic stim_row_t cfg_row(input logic [sbb_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [sbb_pkg::CFG_DATA_W-1:0] val);
        stim_row_t row;
        row = '{ROW_CFG, idx, val, '0, 0, '0};
        return row;
    endfunction

    function automatic stim_row_t pix_row(input logic [7:0] v, input bit valid, input bit typed,
                                          input logic [7:0] wv, input bit wl);
        stim_row_t row;
        row = '{ROW_PIX, sbb_pkg::REG_FRAME_WIDTH, '0, '0, typed, '0};
        row.px.pixel_value = v;
        row.px.pixel_valid = valid;
        row.want.blurred_value = wv;
        row.want.last_of_frame = wl;
        return row;
    endfunction

    // result side: stalls, long hold-off and checking
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (blur_expected.size() == 0) begin
                    report("unexpected result", m_data.blurred_value, -1);
                end else begin
                    sbb_pkg::pixel_out_t want;
                    want = blur_expected.pop_front();
                    results_checked++;
                    if (m_data.blurred_value !== want.blurred_value)
                        report("blurred_value", m_data.blurred_value, want.blurred_value);
                    if (m_data.last_of_frame !== want.last_of_frame)
                        report("last_of_frame", m_data.last_of_frame, want.last_of_frame);
                end
            end
            if (hold_req && hold_cnt == 0) begin
                hold_cnt = HOLD_CYCLES;
                hold_req = 0;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("timeout with %0d results outstanding", blur_expected.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        stim_row_t           dir_rows [$];
        sbb_pkg::pixel_in_t  it;
        int                  phase, nframes, frame_items, abort_at, mode;
        int unsigned         w_val, h_val, r_val;

        // single pixel frames, then a whole-frame window, then a rounding tie
        dir_rows.push_back(cfg_row(sbb_pkg::REG_FRAME_WIDTH, 16'h0000));
        dir_rows.push_back(cfg_row(sbb_pkg::REG_FRAME_HEIGHT, 16'h0000));
        dir_rows.push_back(cfg_row(sbb_pkg::REG_WINDOW_RADIUS, 16'h0000));
        dir_rows.push_back(pix_row(8'hFF, 1, 1, 8'hFF, 1));
        dir_rows.push_back(pix_row(8'h00, 1, 1, 8'h00, 1));
        dir_rows.push_back(pix_row(8'hAA, 0, 0, 0, 0));
        dir_rows.push_back(cfg_row(sbb_pkg::REG_FRAME_WIDTH, 16'd3));
        dir_rows.push_back(cfg_row(sbb_pkg::REG_FRAME_HEIGHT, 16'd2));
        dir_rows.push_back(cfg_row(sbb_pkg::REG_WINDOW_RADIUS, 16'hFFFF));
        for (int i = 0; i < 5; i++) dir_rows.push_back(pix_row(8'hFF, 1, 0, 0, 0));
        dir_rows.push_back(pix_row(8'hFF, 1, 1, 8'hFF, 0));
        for (int i = 0; i < 5; i++) dir_rows.push_back(pix_row(8'h55, 0, 1, 8'hFF, i == 4));
        dir_rows.push_back(cfg_row(sbb_pkg::REG_FRAME_WIDTH, 16'd2));
        dir_rows.push_back(cfg_row(sbb_pkg::REG_FRAME_HEIGHT, 16'd1));
        dir_rows.push_back(pix_row(8'd1, 1, 0, 0, 0));
        dir_rows.push_back(pix_row(8'd2, 1, 1, 8'd2, 0));
        dir_rows.push_back(pix_row(8'd0, 0, 1, 8'd2, 1));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG)
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            else
                send_item(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].want);
        end

        phase = 0;
        while (items_sent < RAND_ITEMS || phase < 8) begin
            mode = phase % 4;
            send_idle_pct  = (mode == 1) ? 51 : (mode == 3) ? 27 : 0;
            recv_stall_pct = (mode == 2) ? 51 : (mode == 3) ? 27 : 0;
            if (phase == 2) hold_req = 1;
            w_val = $urandom_range(12);
            h_val = $urandom_range(10);
            r_val = $urandom_range(15);
            nframes = $urandom_range(1, 3);
            if (phase == 1) begin
                // widest frame, width saturates, abandoned part way
                w_val = 12'hFFF;
                h_val = 1;
                nframes = 1;
            end else if (phase == 3) begin
                // tallest frame, abandoned part way
                w_val = 3;
                h_val = 16'hFFFF;
                nframes = 1;
            end
            write_reg(sbb_pkg::REG_FRAME_WIDTH, {4'($urandom), 12'(w_val)});
            write_reg(sbb_pkg::REG_FRAME_HEIGHT, 16'(h_val));
            write_reg(sbb_pkg::REG_WINDOW_RADIUS, {12'($urandom), 4'(r_val)});
            for (int f = 0; f < nframes; f++) begin
                frame_done = 0;
                frame_items = 0;
                abort_at = -1;
                if (phase == 3) abort_at = 30;
                else if (phase == 1) abort_at = 200;
                else if (f == nframes - 1 && eff_total() > 1 && $urandom_range(7) == 0)
                    abort_at = eff_total() / 2 + 1;
                while (!frame_done && frame_items != abort_at) begin
                    it.pixel_value = $urandom;
                    // mostly well-formed pixels, a few drains mid frame
                    if (px_in_pos < eff_total() || frame_items == 0)
                        it.pixel_valid = ($urandom_range(19) != 0);
                    else
                        it.pixel_valid = ($urandom_range(9) == 0);
                    if (!(it.pixel_valid && px_in_pos >= eff_total() && px_out_pos != 0))
                        items_sent++;
                    send_item(it, 0, '0);
                    frame_items++;
                end
            end
            phase++;
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (blur_expected.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        $display("covered %0d phases, %0d random items, %0d results compared", phase, items_sent,
                 results_checked);
        $display("sizes from 1x1 to full width, radius 0 to 15, stalls and a long output hold");
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
